// ----- design/bbl_pkg.sv -----
// Shared types, constants and the Bark band width table for the band level onset tracker.
package bbl_pkg;

   localparam int TABLE_BANDS = 26;
   localparam int DIV_STEPS   = 16;

   localparam logic [13:0] HEIGHT_MAX = 14'd16383;
   localparam logic [15:0] HALF_Q12   = 16'd2048;

   localparam logic [1:0] REG_HEIGHT_SCALE    = 2'd0;
   localparam logic [1:0] REG_RIPPLE_SCALE    = 2'd1;
   localparam logic [1:0] REG_ONSET_THRESHOLD = 2'd2;
   localparam logic [1:0] REG_PEAK_FLOOR      = 2'd3;

   localparam logic [3:0]  HEIGHT_SCALE_RST    = 4'd3;
   localparam logic [3:0]  RIPPLE_SCALE_RST    = 4'd10;
   localparam logic [12:0] ONSET_THRESHOLD_RST = 13'd1024;
   localparam logic [15:0] PEAK_FLOOR_RST      = 16'd6;

   localparam logic [6:0] BARK_WIDTH [TABLE_BANDS] = '{
      7'd2, 7'd2, 7'd2, 7'd2, 7'd2, 7'd3, 7'd3, 7'd3, 7'd3, 7'd4, 7'd4, 7'd5, 7'd6,
      7'd7, 7'd8, 7'd10, 7'd12, 7'd15, 7'd19, 7'd23, 7'd28, 7'd38, 7'd53, 7'd75,
      7'd90, 7'd94
   };

   typedef enum logic [3:0] {
      S_SWEEP,
      S_IDLE,
      S_FETCH,
      S_RATIO_GO,
      S_RATIO_WAIT,
      S_SMOOTH_GO,
      S_SMOOTH_WAIT,
      S_MEAN_GO,
      S_MEAN_WAIT,
      S_DRAT_GO,
      S_DRAT_WAIT,
      S_CHG_GO,
      S_CHG_WAIT,
      S_FINISH
   } state_type;

   typedef struct packed {
      logic        start;
      logic [31:0] dividend;
      logic [15:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic        done;
      logic [15:0] quotient;
   } div_rsp_type;

   // band width; bands past the table are one bin wide
   function automatic logic [6:0] bark_width(input logic [6:0] band);
      logic [6:0] w;
      if (band < 7'(TABLE_BANDS)) begin
         w = BARK_WIDTH[band[4:0]];
      end else begin
         w = 7'd1;
      end
      return w;
   endfunction

endpackage

// ----- design/bbl_if.sv -----
// Request and response channel interfaces of the band level onset tracker.
interface bbl_req_if;
   logic        valid;
   logic        ready;
   logic [15:0] bin_magnitude;
   logic        first_of_frame;

   modport source (output valid, output bin_magnitude, output first_of_frame, input ready);
   modport sink   (input valid, input bin_magnitude, input first_of_frame, output ready);
endinterface

interface bbl_rsp_if;
   logic               valid;
   logic               ready;
   logic        [13:0] bin_height;
   logic               band_done;
   logic        [4:0]  band_number;
   logic        [15:0] band_level;
   logic signed [16:0] change_value;
   logic               onset_flag;
   logic        [15:0] onset_strength;
   logic               frame_done;

   modport source (output valid, output bin_height, output band_done, output band_number,
                   output band_level, output change_value, output onset_flag,
                   output onset_strength, output frame_done, input ready);
   modport sink   (input valid, input bin_height, input band_done, input band_number,
                   input band_level, input change_value, input onset_flag,
                   input onset_strength, input frame_done, output ready);
endinterface

// ----- design/bbl_div.sv -----
// Shared restoring divider: 16 quotient bits, one bit a cycle.
module bbl_div (
   input  logic                clock,
   input  logic                reset,
   input  bbl_pkg::div_req_type req,
   output bbl_pkg::div_rsp_type rsp
);
   import bbl_pkg::*;

   logic        busy_ff, done_ff, zero_ff;
   logic [4:0]  cnt_ff;
   logic [15:0] rem_ff, low_ff, den_ff;
   logic [16:0] trial;
   logic        ge;
   logic [15:0] rem_in, low_in;

   // caller guarantees the quotient fits in 16 bits, so the top half is below the divisor
   always_comb begin
      trial  = {rem_ff, low_ff[15]};
      ge     = trial >= {1'b0, den_ff};
      rem_in = ge ? 16'(trial - {1'b0, den_ff}) : trial[15:0];
      low_in = {low_ff[14:0], ge};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (req.start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= 5'(DIV_STEPS);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 5'd1;
            if (cnt_ff == 5'd1) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req.start) begin
         rem_ff  <= req.dividend[31:16];
         low_ff  <= req.dividend[15:0];
         den_ff  <= req.divisor;
         zero_ff <= (req.divisor == 16'd0);
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         low_ff <= low_in;
      end
   end

   assign rsp.done     = done_ff;
   assign rsp.quotient = zero_ff ? 16'd0 : low_ff;

endmodule

// ----- design/bark_band_level_onset_tracker.sv -----
// Bark band level onset tracker: one bin per transaction through a shared serial divider.
// A bin inside a band takes two divisions (ratio, smoothing); a bin that closes a band
// takes five (ratio, smoothing, mean, band ratio, change), all on the single shared divider,
// which sets the rate. One bin is in flight at a time, so the next bin is taken only after
// the last one is loaded into the output register, later if the receiver still holds it.
// Reset: synchronous, active high; a clearing pass then loads every bin peak with the floor
// and zeroes every bin height. A peak_floor write while idle or sweeping reruns the peak pass.
module bark_band_level_onset_tracker #(
   parameter int NUM_BINS  = 513,
   parameter int NUM_BANDS = 26
) (
   input  logic        clock,
   input  logic        reset,
   bbl_req_if.sink     req_if,
   bbl_rsp_if.source   rsp_if,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [3:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);
   import bbl_pkg::*;

   localparam int BIN_W  = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
   localparam int BAND_W = (NUM_BANDS > 1) ? $clog2(NUM_BANDS) : 1;
   localparam logic [BIN_W-1:0]  LAST_BIN  = BIN_W'(NUM_BINS - 1);
   localparam logic [BAND_W-1:0] LAST_BAND = BAND_W'(NUM_BANDS - 1);

   // ---------------------------------------------------------------- registers
   logic [3:0]  hs_ff, rs_ff;
   logic [12:0] thr_ff;
   logic [15:0] floor_ff;
   logic        cfg_wr, peak_wr;

   assign pready  = 1'b1;
   assign cfg_wr  = psel & penable & pwrite;
   assign peak_wr = cfg_wr && (paddr[3:2] == REG_PEAK_FLOOR);

   always_ff @(posedge clock) begin
      if (reset) begin
         hs_ff    <= HEIGHT_SCALE_RST;
         rs_ff    <= RIPPLE_SCALE_RST;
         thr_ff   <= ONSET_THRESHOLD_RST;
         floor_ff <= PEAK_FLOOR_RST;
      end else if (cfg_wr) begin
         case (paddr[3:2])
            REG_HEIGHT_SCALE:    hs_ff    <= pwdata[3:0];
            REG_RIPPLE_SCALE:    rs_ff    <= pwdata[3:0];
            REG_ONSET_THRESHOLD: thr_ff   <= pwdata[12:0];
            REG_PEAK_FLOOR:      floor_ff <= pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (paddr[3:2])
         REG_HEIGHT_SCALE:    prdata = {28'd0, hs_ff};
         REG_RIPPLE_SCALE:    prdata = {28'd0, rs_ff};
         REG_ONSET_THRESHOLD: prdata = {19'd0, thr_ff};
         REG_PEAK_FLOOR:      prdata = {16'd0, floor_ff};
         default:             prdata = 32'd0;
      endcase
   end

   // a zero scale acts as one
   logic [3:0] hs_eff, rs_eff;
   assign hs_eff = (hs_ff == 4'd0) ? 4'd1 : hs_ff;
   assign rs_eff = (rs_ff == 4'd0) ? 4'd1 : rs_ff;

   // ---------------------------------------------------------------- state
   state_type state_ff, state_in;

   logic [BIN_W-1:0]  bin_ff;
   logic [BAND_W-1:0] band_ff;
   logic [6:0]        left_ff;
   logic [25:0]       acc_ff;

   logic [BIN_W-1:0]  sweep_ff;
   logic              sweep_hgt_ff;

   // working copy of the transaction in flight
   logic [15:0]       m_ff;
   logic [BIN_W-1:0]  bin_w_ff;
   logic [BAND_W-1:0] band_w_ff;
   logic              close_ff, last_ff;
   logic [6:0]        n_ff;
   logic [25:0]       sum_ff;

   logic [15:0] pk_rd_ff;
   logic [13:0] hg_rd_ff;
   logic        diff_neg_ff;
   logic [16:0] diff_abs_ff;
   logic [13:0] h_new_ff;
   logic [15:0] mean_ff;
   logic        chg_neg_ff;
   logic [16:0] chg_abs_ff;
   logic [15:0] lvl_out_ff;
   logic signed [16:0] change_ff;
   logic        onset_ff;
   logic [15:0] strength_ff;

   logic [15:0] bpk_ff  [NUM_BANDS];
   logic [15:0] blvl_ff [NUM_BANDS];

   logic        rsp_valid_ff;
   logic [13:0] o_height_ff;
   logic        o_band_done_ff, o_frame_done_ff, o_onset_ff;
   logic [4:0]  o_band_ff;
   logic [15:0] o_level_ff, o_strength_ff;
   logic signed [16:0] o_change_ff;

   // arithmetic step results
   logic signed [17:0] diff, h_sum, chg_num, lvl_sum, q_s, half_s;
   logic [13:0] h_new;
   logic [15:0] lvl_new, q_half;

   div_req_type div_req;
   div_rsp_type div_rsp;

   bbl_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   logic accept, out_free, load_out;
   assign req_if.ready = (state_ff == S_IDLE) && !peak_wr;
   assign accept       = req_if.valid && req_if.ready;
   assign out_free     = !rsp_valid_ff || rsp_if.ready;
   assign load_out     = (state_ff == S_FINISH) && out_free;

   // ---------------------------------------------------------------- bin and band counters
   // every counter update depends only on the counters, first_of_frame and the bin magnitude, so advance at accept
   logic [BIN_W-1:0]  b0;
   logic [BAND_W-1:0] band0, band_nx;
   logic [6:0]        left0, width0, leftc, n0;
   logic [25:0]       acc0, accsum;
   logic              last0, close0;

   always_comb begin
      b0    = req_if.first_of_frame ? '0 : bin_ff;
      if ({1'b0, b0} >= (BIN_W+1)'(NUM_BINS)) begin
         b0 = '0;
      end
      band0 = req_if.first_of_frame ? '0 : band_ff;
      if ({1'b0, band0} >= (BAND_W+1)'(NUM_BANDS)) begin
         band0 = LAST_BAND;
      end
      left0  = req_if.first_of_frame ? bark_width(7'd0) : left_ff;
      acc0   = req_if.first_of_frame ? 26'd0 : acc_ff;
      width0 = bark_width(7'(band0));
      last0  = (b0 == LAST_BIN);
      close0 = (left0 <= 7'd1) || last0;
      accsum = acc0 + {10'd0, req_if.bin_magnitude};
      leftc  = ((left0 == 7'd0) || (left0 > width0)) ? width0 : left0;
      n0     = width0 - leftc + 7'd1;
      band_nx = (({1'b0, band0} + (BAND_W+1)'(1)) < (BAND_W+1)'(NUM_BANDS))
                ? BAND_W'(band0 + BAND_W'(1)) : band0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bin_ff  <= '0;
         band_ff <= '0;
         left_ff <= bark_width(7'd0);
         acc_ff  <= '0;
      end else if (accept) begin
         if (last0) begin
            // frame end: restart at bin 0, band 0
            bin_ff  <= '0;
            band_ff <= '0;
            left_ff <= bark_width(7'd0);
            acc_ff  <= '0;
         end else begin
            bin_ff <= BIN_W'(b0 + BIN_W'(1));
            if (close0) begin
               band_ff <= band_nx;
               left_ff <= bark_width(7'(band_nx));
               acc_ff  <= '0;
            end else begin
               band_ff <= band0;
               left_ff <= left0 - 7'd1;
               acc_ff  <= accsum;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         m_ff      <= req_if.bin_magnitude;
         bin_w_ff  <= b0;
         band_w_ff <= band0;
         close_ff  <= close0;
         last_ff   <= last0;
         n_ff      <= n0;
         sum_ff    <= accsum;
      end
   end

   // ---------------------------------------------------------------- sequencer
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_SWEEP: begin
            if (!peak_wr && (sweep_ff == LAST_BIN)) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (peak_wr)     state_in = S_SWEEP;
            else if (accept) state_in = S_FETCH;
         end
         S_FETCH:       state_in = S_RATIO_GO;
         S_RATIO_GO:    state_in = S_RATIO_WAIT;
         S_RATIO_WAIT:  if (div_rsp.done) state_in = S_SMOOTH_GO;
         S_SMOOTH_GO:   state_in = S_SMOOTH_WAIT;
         S_SMOOTH_WAIT: if (div_rsp.done) state_in = close_ff ? S_MEAN_GO : S_FINISH;
         S_MEAN_GO:     state_in = S_MEAN_WAIT;
         S_MEAN_WAIT:   if (div_rsp.done) state_in = S_DRAT_GO;
         S_DRAT_GO:     state_in = S_DRAT_WAIT;
         S_DRAT_WAIT:   if (div_rsp.done) state_in = S_CHG_GO;
         S_CHG_GO:      state_in = S_CHG_WAIT;
         S_CHG_WAIT:    if (div_rsp.done) state_in = S_FINISH;
         S_FINISH:      if (out_free) state_in = S_IDLE;
         default:       state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_SWEEP;
      else       state_ff <= state_in;
   end

   // ---------------------------------------------------------------- shared divider requests
   logic [15:0] pk_upd, bpk_rd, bpk_upd, lvl_rd;
   logic [19:0] hs_m, rs_mean;

   assign pk_upd  = (m_ff > pk_rd_ff) ? m_ff : pk_rd_ff;
   assign bpk_rd  = bpk_ff[band_w_ff];
   assign bpk_upd = (mean_ff > bpk_rd) ? mean_ff : bpk_rd;
   assign lvl_rd  = blvl_ff[band_w_ff];
   assign hs_m    = 20'(hs_eff * m_ff);
   assign rs_mean = 20'(rs_eff * mean_ff);

   always_comb begin
      div_req = '0;
      case (state_ff)
         S_RATIO_GO: begin
            // height_scale * m / peak in Q4.12
            div_req.start    = 1'b1;
            div_req.dividend = {hs_m, 12'd0};
            div_req.divisor  = pk_upd;
         end
         S_SMOOTH_GO: begin
            div_req.start    = 1'b1;
            div_req.dividend = {15'd0, diff_abs_ff};
            div_req.divisor  = {11'd0, hs_eff, 1'b0};
         end
         S_MEAN_GO: begin
            div_req.start    = 1'b1;
            div_req.dividend = {6'd0, sum_ff};
            div_req.divisor  = {9'd0, n_ff};
         end
         S_DRAT_GO: begin
            div_req.start    = 1'b1;
            div_req.dividend = {rs_mean, 12'd0};
            div_req.divisor  = bpk_upd;
         end
         S_CHG_GO: begin
            div_req.start    = 1'b1;
            div_req.dividend = {15'd0, chg_abs_ff};
            div_req.divisor  = {12'd0, rs_eff};
         end
         default: div_req = '0;
      endcase
   end

   // ---------------------------------------------------------------- bin memories
   logic [15:0] peak_mem [NUM_BINS];
   logic [13:0] hgt_mem  [NUM_BINS];

   always_ff @(posedge clock) begin
      if (state_ff == S_SWEEP) begin
         peak_mem[sweep_ff] <= floor_ff;
      end else if (state_ff == S_RATIO_GO) begin
         peak_mem[bin_w_ff] <= pk_upd;
      end
      if (state_ff == S_FETCH) begin
         pk_rd_ff <= peak_mem[bin_w_ff];
      end
   end

   always_ff @(posedge clock) begin
      if ((state_ff == S_SWEEP) && sweep_hgt_ff) begin
         hgt_mem[sweep_ff] <= 14'd0;
      end else if ((state_ff == S_SMOOTH_WAIT) && div_rsp.done) begin
         hgt_mem[bin_w_ff] <= h_new;
      end
      if (state_ff == S_FETCH) begin
         hg_rd_ff <= hgt_mem[bin_w_ff];
      end
   end

   // clearing pass; a floor write restarts it and leaves heights alone once the reset pass is done
   always_ff @(posedge clock) begin
      if (reset) begin
         sweep_ff     <= '0;
         sweep_hgt_ff <= 1'b1;
      end else if (peak_wr) begin
         sweep_ff <= '0;
      end else if (state_ff == S_SWEEP) begin
         if (sweep_ff == LAST_BIN) begin
            sweep_ff     <= '0;
            sweep_hgt_ff <= 1'b0;
         end else begin
            sweep_ff <= sweep_ff + BIN_W'(1);
         end
      end
   end

   // ---------------------------------------------------------------- arithmetic steps
   always_comb begin
      q_s     = $signed({2'b00, div_rsp.quotient});
      q_half  = {1'b0, div_rsp.quotient[15:1]};
      half_s  = $signed({2'b00, q_half});

      diff    = $signed({2'b00, div_rsp.quotient}) - $signed({4'd0, hg_rd_ff});

      h_sum   = $signed({4'd0, hg_rd_ff}) + (diff_neg_ff ? -q_s : q_s);
      if (h_sum < 0)                              h_new = 14'd0;
      else if (h_sum > $signed({4'd0, HEIGHT_MAX})) h_new = HEIGHT_MAX;
      else                                        h_new = h_sum[13:0];

      chg_num = $signed({2'b00, div_rsp.quotient}) - $signed({2'b00, lvl_rd});

      // level moves by half the change, truncated toward zero
      lvl_sum = $signed({2'b00, lvl_rd}) + (chg_neg_ff ? -half_s : half_s);
      if (lvl_sum < 0)                     lvl_new = 16'd0;
      else if (lvl_sum > 18'sd65535)       lvl_new = 16'hFFFF;
      else                                 lvl_new = lvl_sum[15:0];
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         S_RATIO_WAIT: begin
            if (div_rsp.done) begin
               diff_neg_ff <= diff[17];
               diff_abs_ff <= diff[17] ? 17'(-diff) : diff[16:0];
            end
         end
         S_SMOOTH_WAIT: begin
            if (div_rsp.done) begin
               h_new_ff    <= h_new;
               lvl_out_ff  <= 16'd0;
               change_ff   <= '0;
               onset_ff    <= 1'b0;
               strength_ff <= 16'd0;
            end
         end
         S_MEAN_WAIT: begin
            if (div_rsp.done) mean_ff <= div_rsp.quotient;
         end
         S_DRAT_WAIT: begin
            if (div_rsp.done) begin
               chg_neg_ff <= chg_num[17];
               chg_abs_ff <= chg_num[17] ? 17'(-chg_num) : chg_num[16:0];
            end
         end
         S_CHG_WAIT: begin
            if (div_rsp.done) begin
               lvl_out_ff <= lvl_new;
               change_ff  <= chg_neg_ff ? -$signed({1'b0, div_rsp.quotient})
                                        : $signed({1'b0, div_rsp.quotient});
               // onset only on a positive change above the threshold
               onset_ff   <= !chg_neg_ff && (div_rsp.quotient > {3'd0, thr_ff});
               strength_ff <= (!chg_neg_ff && (div_rsp.quotient > {3'd0, thr_ff}))
                              ? 16'(q_half + HALF_Q12) : 16'd0;
            end
         end
         default: ;
      endcase
   end

   // band peaks and levels; a floor write reloads every band peak at once
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_BANDS; i++) begin
            bpk_ff[i]  <= PEAK_FLOOR_RST;
            blvl_ff[i] <= 16'd0;
         end
      end else begin
         if (peak_wr) begin
            for (int i = 0; i < NUM_BANDS; i++) bpk_ff[i] <= pwdata[15:0];
         end else if (state_ff == S_DRAT_GO) begin
            bpk_ff[band_w_ff] <= bpk_upd;
         end
         if ((state_ff == S_CHG_WAIT) && div_rsp.done) begin
            blvl_ff[band_w_ff] <= lvl_new;
         end
      end
   end

   // ---------------------------------------------------------------- output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         o_height_ff     <= h_new_ff;
         o_band_done_ff  <= close_ff;
         o_band_ff       <= 5'(band_w_ff);
         o_level_ff      <= lvl_out_ff;
         o_change_ff     <= change_ff;
         o_onset_ff      <= onset_ff;
         o_strength_ff   <= strength_ff;
         o_frame_done_ff <= last_ff;
      end
   end

   assign rsp_if.valid          = rsp_valid_ff;
   assign rsp_if.bin_height     = o_height_ff;
   assign rsp_if.band_done      = o_band_done_ff;
   assign rsp_if.band_number    = o_band_ff;
   assign rsp_if.band_level     = o_level_ff;
   assign rsp_if.change_value   = o_change_ff;
   assign rsp_if.onset_flag     = o_onset_ff;
   assign rsp_if.onset_strength = o_strength_ff;
   assign rsp_if.frame_done     = o_frame_done_ff;

endmodule
